// ===== sv/rbp_pkg.sv =====
// Shared definitions for the reference-counted buffer pool.
// Request and status codes, field widths and the free-stack operation type.
// No dependencies.
package rbp_pkg;

  localparam int unsigned DEFAULT_MAX_BUFFERS = 32;

  localparam int unsigned REQ_W    = 2;
  localparam int unsigned ID_W     = 5;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 8;

  localparam logic [REQ_W-1:0] REQ_GET     = 2'd0;
  localparam logic [REQ_W-1:0] REQ_ADD     = 2'd1;
  localparam logic [REQ_W-1:0] REQ_RELEASE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK               = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OUT_OF_BUFFERS   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ALREADY_RELEASED = 2'd2;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 8'd255;

  // One operation on the free stack per request at most.
  typedef struct packed {
    logic push;
    logic pop;
  } rbp_stack_op_t;

endpackage

// ===== sv/rbp_req_if.sv =====
// Request channel of the buffer pool: valid/ready handshake plus payload.
// Depends on rbp_pkg for field widths.
interface rbp_req_if import rbp_pkg::*;;
  logic               valid;
  logic               ready;
  logic [REQ_W-1:0]   req_type;
  logic [ID_W-1:0]    buf_id;

  modport source (output valid, output req_type, output buf_id, input ready);
  modport sink   (input valid, input req_type, input buf_id, output ready);
endinterface

// ===== sv/rbp_rsp_if.sv =====
// Result channel of the buffer pool: valid/ready handshake plus payload.
// Depends on rbp_pkg for field widths.
interface rbp_rsp_if import rbp_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [STATUS_W-1:0]  status;
  logic [ID_W-1:0]      granted_id;
  logic [COUNT_W-1:0]   count_after;

  modport source (output valid, output status, output granted_id, output count_after,
                  input ready);
  modport sink   (input valid, input status, input granted_id, input count_after,
                  output ready);
endinterface

// ===== sv/refcounted_buffer_pool.sv =====
// Reference-counted buffer pool. An accepted request is registered in the execute stage,
// then its result in the output register, from which it transfers. Throughput: one request
// per cycle while rsp.ready is high; with a result held, one more request is taken.
// Synchronous active-high rst empties the pipeline and clears the free-stack depth
// and the created-id count; the count RAM is not cleared, since a fresh id is written
// as one without a read and counts at or beyond the created-id count are never used.
module refcounted_buffer_pool import rbp_pkg::*; #(
  parameter int unsigned MAX_BUFFERS = DEFAULT_MAX_BUFFERS
) (
  input  logic     clk,
  input  logic     rst,
  rbp_req_if.sink  req,
  rbp_rsp_if.source rsp
);

  localparam int unsigned IDX_W   = $clog2(MAX_BUFFERS);
  localparam int unsigned DEPTH_W = $clog2(MAX_BUFFERS+1);
  localparam int unsigned CMP_W   = (DEPTH_W > ID_W) ? DEPTH_W : ID_W;
  localparam logic [DEPTH_W-1:0] FULL = DEPTH_W'(MAX_BUFFERS);

  // Execute stage: the accepted request, with its count arriving from the RAM.
  logic               e_valid;
  logic [REQ_W-1:0]   e_req;
  logic [ID_W-1:0]    e_id;
  logic [IDX_W-1:0]   e_addr;
  logic               e_adv;

  // Last count write, forwarded when the RAM read raced with it.
  logic               lw_valid;
  logic [IDX_W-1:0]   lw_addr;
  logic [COUNT_W-1:0] lw_data;

  logic [DEPTH_W-1:0] created;
  logic [DEPTH_W-1:0] created_next;

  logic [DEPTH_W-1:0] depth;
  logic [DEPTH_W-1:0] depth_next;
  logic [IDX_W-1:0]   top_next;
  rbp_stack_op_t      stack_op;

  logic               accept;
  logic [IDX_W-1:0]   acc_addr;
  logic [COUNT_W-1:0] cnt_rdata;
  logic [COUNT_W-1:0] cur_count;
  logic [COUNT_W-1:0] inc_count;
  logic               id_known;
  logic               cnt_we;
  logic [COUNT_W-1:0] cnt_wdata;

  logic [STATUS_W-1:0] res_status;
  logic [ID_W-1:0]     res_granted;
  logic [COUNT_W-1:0]  res_count;

  // Output register.
  logic                o_valid;
  logic [STATUS_W-1:0] o_status;
  logic [ID_W-1:0]     o_granted;
  logic [COUNT_W-1:0]  o_count;

  // Advance the execute stage whenever the output register is free or draining.
  assign e_adv     = e_valid && (!o_valid || rsp.ready);
  assign req.ready = !e_valid || e_adv;
  assign accept    = req.valid && req.ready;

  // Read address for the count RAM, formed against the state as it stands once
  // the request now in execute has finished.
  always_comb begin
    if (req.req_type == REQ_GET) begin
      acc_addr = (depth_next != '0) ? top_next : IDX_W'(created_next);
    end else begin
      acc_addr = IDX_W'(req.buf_id);
    end
  end

  assign cur_count = (lw_valid && (lw_addr == e_addr)) ? lw_data : cnt_rdata;
  assign inc_count = (cur_count == COUNT_MAX) ? cur_count : cur_count + COUNT_W'(1);
  assign id_known  = CMP_W'(e_id) < CMP_W'(created);

  always_comb begin
    stack_op     = '0;
    cnt_we       = 1'b0;
    cnt_wdata    = cur_count;
    created_next = created;
    res_status   = ST_OK;
    res_granted  = '0;
    res_count    = '0;
    unique case (e_req)
      REQ_GET: begin
        if (depth != '0) begin
          // Reuse the most recently freed id.
          stack_op.pop = e_adv;
          cnt_we       = 1'b1;
          cnt_wdata    = inc_count;
          res_granted  = ID_W'(e_addr);
          res_count    = inc_count;
        end else if (created != FULL) begin
          // Create a fresh id; its count starts at one.
          if (e_adv) begin
            created_next = created + DEPTH_W'(1);
          end
          cnt_we      = 1'b1;
          cnt_wdata   = COUNT_W'(1);
          res_granted = ID_W'(e_addr);
          res_count   = COUNT_W'(1);
        end else begin
          res_status = ST_OUT_OF_BUFFERS;
        end
      end
      REQ_ADD: begin
        if (id_known) begin
          cnt_we    = 1'b1;
          cnt_wdata = inc_count;
          res_count = inc_count;
        end
      end
      REQ_RELEASE: begin
        if (id_known && (cur_count != '0)) begin
          cnt_we    = 1'b1;
          cnt_wdata = cur_count - COUNT_W'(1);
          res_count = cur_count - COUNT_W'(1);
          // Drop the push when the stack is already full.
          stack_op.push = e_adv && (cur_count == COUNT_W'(1)) && (depth != FULL);
        end else begin
          res_status = ST_ALREADY_RELEASED;
        end
      end
      default: begin
        // Unused request code: nothing changes.
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid  <= 1'b0;
      lw_valid <= 1'b0;
      created  <= '0;
      o_valid  <= 1'b0;
    end else begin
      if (accept) begin
        e_valid <= 1'b1;
      end else if (e_adv) begin
        e_valid <= 1'b0;
      end
      if (e_adv && cnt_we) begin
        lw_valid <= 1'b1;
      end
      created <= created_next;
      if (e_adv) begin
        o_valid <= 1'b1;
      end else if (rsp.ready) begin
        o_valid <= 1'b0;
      end
    end
    if (accept) begin
      e_req  <= req.req_type;
      e_id   <= req.buf_id;
      e_addr <= acc_addr;
    end
    if (e_adv && cnt_we) begin
      lw_addr <= e_addr;
      lw_data <= cnt_wdata;
    end
    if (e_adv) begin
      o_status  <= res_status;
      o_granted <= res_granted;
      o_count   <= res_count;
    end
  end

  assign rsp.valid       = o_valid;
  assign rsp.status      = o_status;
  assign rsp.granted_id  = o_granted;
  assign rsp.count_after = o_count;

  rbp_free_stack #(
    .MAX_BUFFERS (MAX_BUFFERS)
  ) u_free_stack (
    .clk        (clk),
    .rst        (rst),
    .op         (stack_op),
    .push_id    (e_addr),
    .depth      (depth),
    .depth_next (depth_next),
    .top_next   (top_next)
  );

  // Reference counts, one entry per id; read at transfer, written on advance.
  rbp_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (MAX_BUFFERS)
  ) u_count_ram (
    .clk   (clk),
    .we    (e_adv && cnt_we),
    .waddr (e_addr),
    .wdata (cnt_wdata),
    .re    (accept),
    .raddr (acc_addr),
    .rdata (cnt_rdata)
  );

endmodule

// ===== sv/rbp_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module rbp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/rbp_free_stack.sv =====
// LIFO of freed buffer ids: top two entries cached in registers, rest in a RAM.
// Depends on rbp_pkg (rbp_stack_op_t) and rbp_ram.
module rbp_free_stack import rbp_pkg::*; #(
  parameter int unsigned MAX_BUFFERS = DEFAULT_MAX_BUFFERS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  rbp_stack_op_t                      op,
  input  logic [$clog2(MAX_BUFFERS)-1:0]     push_id,
  output logic [$clog2(MAX_BUFFERS+1)-1:0]   depth,
  output logic [$clog2(MAX_BUFFERS+1)-1:0]   depth_next,
  output logic [$clog2(MAX_BUFFERS)-1:0]     top_next
);

  localparam int unsigned IDX_W   = $clog2(MAX_BUFFERS);
  localparam int unsigned DEPTH_W = $clog2(MAX_BUFFERS+1);

  logic [IDX_W-1:0] top;
  logic [IDX_W-1:0] second;
  logic [IDX_W-1:0] second_next;
  logic [IDX_W-1:0] below;
  logic [DEPTH_W-1:0] below_addr;

  always_comb begin
    depth_next  = depth;
    top_next    = top;
    second_next = second;
    if (op.push) begin
      depth_next  = depth + DEPTH_W'(1);
      top_next    = push_id;
      second_next = top;
    end else if (op.pop) begin
      depth_next  = depth - DEPTH_W'(1);
      top_next    = second;
      second_next = below;
    end
  end

  // Prefetch the entry that sits under the cached pair after this cycle.
  assign below_addr = depth_next - DEPTH_W'(3);

  always_ff @(posedge clk) begin
    if (rst) begin
      depth <= '0;
    end else begin
      depth <= depth_next;
    end
    top    <= top_next;
    second <= second_next;
  end

  rbp_ram #(
    .WIDTH (IDX_W),
    .DEPTH (MAX_BUFFERS)
  ) u_stack_ram (
    .clk   (clk),
    .we    (op.push),
    .waddr (IDX_W'(depth)),
    .wdata (push_id),
    .re    (1'b1),
    .raddr (IDX_W'(below_addr)),
    .rdata (below)
  );

endmodule
